>>> src/wih_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wih_pkg;

   // Default sizes of the hit-count store and the column mapping.
   localparam int DEF_COLUMNS    = 1024;
   localparam int DEF_COUNT_BITS = 16;
   localparam int DEF_SHIFT      = 16;

   // The level axis is fixed by the 8-bit sample.
   localparam int LEVEL_BITS = 8;
   localparam int LEVELS     = 1 << LEVEL_BITS;

   // Field widths.
   localparam int FUNC_BITS      = 2;
   localparam int INDEX_BITS     = 16;
   localparam int COLUMN_BITS    = 10;
   localparam int HIT_BITS       = 16;
   localparam int ROW_BITS       = 12;
   localparam int XSCALE_BITS    = 17;
   localparam int GAIN_BITS      = 12;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 17;

   // Command codes.
   localparam logic [FUNC_BITS-1:0] FUNC_ACCUM = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_READ  = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_CLEAR = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_X_SCALE        = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLOR_RED      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLOR_GREEN    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLOR_BLUE     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_SCALE      = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISPLAY_HEIGHT = 3'd5;

   // Register reset values.
   localparam logic [XSCALE_BITS-1:0] RST_X_SCALE        = 17'd65536;
   localparam logic [GAIN_BITS-1:0]   RST_GAIN           = 12'd256;
   localparam logic [GAIN_BITS-1:0]   RST_ROW_SCALE      = 12'd256;
   localparam logic [ROW_BITS-1:0]    RST_DISPLAY_HEIGHT = 12'd256;

   // Levels that an accumulate never counts.
   localparam logic [LEVEL_BITS-1:0] LEVEL_FLOOR = 8'h00;
   localparam logic [LEVEL_BITS-1:0] LEVEL_CEIL  = 8'hff;

   // Pixel and row limits.
   localparam logic [7:0]          PIXEL_ALPHA = 8'hff;
   localparam logic [7:0]          CHANNEL_MAX = 8'hff;
   localparam logic [ROW_BITS-1:0] ROW_MAX     = 12'd4095;

   typedef struct packed {
      logic [FUNC_BITS-1:0]   func;
      logic [INDEX_BITS-1:0]  sample_index;
      logic [LEVEL_BITS-1:0]  sample_value;
      logic [COLUMN_BITS-1:0] read_column;
      logic [LEVEL_BITS-1:0]  read_level;
   } req_type;

   typedef struct packed {
      logic [HIT_BITS-1:0]    hit_count;
      logic                   paint;
      logic [31:0]            pixel_argb;
      logic [COLUMN_BITS-1:0] pixel_column;
      logic [ROW_BITS-1:0]    row_top;
      logic [ROW_BITS-1:0]    row_bottom;
   } rsp_type;

   // Settings that the shading stage needs from the register file.
   typedef struct packed {
      logic [GAIN_BITS-1:0] color_red;
      logic [GAIN_BITS-1:0] color_green;
      logic [GAIN_BITS-1:0] color_blue;
      logic [ROW_BITS-1:0]  display_height;
   } shade_cfg_type;

   // Display rows covered by one level, before the vertical flip.
   typedef struct packed {
      logic [ROW_BITS-1:0] span_lo;
      logic [ROW_BITS-1:0] span_hi;
   } span_type;

endpackage

`default_nettype wire

>>> src/wih_shade.sv
`timescale 1ns / 1ps
`default_nettype none

module wih_shade #(
   parameter int COUNT_BITS = wih_pkg::DEF_COUNT_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               go,
   input  wire logic [COUNT_BITS-1:0]              count,
   input  wire logic [wih_pkg::COLUMN_BITS-1:0]    column,
   input  wire wih_pkg::span_type                  span,
   input  wire wih_pkg::shade_cfg_type             cfg,
   output logic                                    rsp_valid,
   output wih_pkg::rsp_type                        rsp_payload
);
   import wih_pkg::*;

   localparam int PROD_BITS = GAIN_BITS + COUNT_BITS;

   logic [PROD_BITS-1:0]   red_ff, green_ff, blue_ff;
   logic [HIT_BITS-1:0]    count_ff;
   logic [COLUMN_BITS-1:0] column_ff;
   logic                   paint_ff;
   logic [ROW_BITS-1:0]    top_ff, bottom_ff;
   logic                   valid1_ff, valid2_ff;
   rsp_type                rsp_ff;

   logic [ROW_BITS+1:0]    top_in, bottom_in;

   // Channel value is the product over 256, capped at full scale.
   function automatic logic [7:0] scale_channel(input logic [PROD_BITS-1:0] prod);
      logic [7:0] result;
      if (|prod[PROD_BITS-1:16]) begin
         result = CHANNEL_MAX;
      end else begin
         result = prod[15:8];
      end
      return result;
   endfunction

   // Flipped row bounds, in two extra bits to see the sign and the overflow.
   assign top_in    = {2'b00, cfg.display_height} - {2'b00, span.span_hi}
                      + (ROW_BITS + 2)'(1);
   assign bottom_in = {2'b00, cfg.display_height} - {2'b00, span.span_lo};

   // First stage: gain products and clamped rows.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= go;
      end
      if (go) begin
         red_ff    <= PROD_BITS'(cfg.color_red) * PROD_BITS'(count);
         green_ff  <= PROD_BITS'(cfg.color_green) * PROD_BITS'(count);
         blue_ff   <= PROD_BITS'(cfg.color_blue) * PROD_BITS'(count);
         count_ff  <= HIT_BITS'(count);
         column_ff <= column;
         paint_ff  <= (count != '0) && (span.span_hi > span.span_lo);
         if (top_in[ROW_BITS+1]) begin
            top_ff <= '0;
         end else if (top_in[ROW_BITS]) begin
            top_ff <= ROW_MAX;
         end else begin
            top_ff <= top_in[ROW_BITS-1:0];
         end
         if (bottom_in[ROW_BITS+1]) begin
            bottom_ff <= '0;
         end else begin
            bottom_ff <= bottom_in[ROW_BITS-1:0];
         end
      end
   end

   // Second stage: saturate the channels and register the result beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= valid1_ff;
      end
      if (valid1_ff) begin
         rsp_ff.hit_count    <= count_ff;
         rsp_ff.paint        <= paint_ff;
         rsp_ff.pixel_argb   <= {PIXEL_ALPHA, scale_channel(blue_ff),
                                 scale_channel(green_ff), scale_channel(red_ff)};
         rsp_ff.pixel_column <= column_ff;
         rsp_ff.row_top      <= top_ff;
         rsp_ff.row_bottom   <= bottom_ff;
      end
   end

   assign rsp_valid   = valid2_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

>>> src/waveform_intensity_histogram.sv
`timescale 1ns / 1ps
`default_nettype none

// Intensity-grading histogram over a store of COLUMNS x 256 hit counts held in
// one single-port-write, registered-read memory. Items are taken one at a
// time while busy is low. An accumulate maps the column, reads the cell and
// writes back the incremented count before the next item is taken; one that
// is dropped for its level or column leaves at the lookup without a write. A
// read goes through the lookup and data states and the shading stages, and its
// result beat appears on rsp_valid for one cycle only; results cannot be held off,
// and none is lost, since the shading pipeline behind the memory takes a new cell
// every cycle. A clear command, and likewise the end of reset, runs a clearing
// pass over all COLUMNS x 256 cells of the memory, one cell a cycle, during
// which busy stays high; the configuration port is always ready, even then. An
// unused command code is taken and does nothing.
module waveform_intensity_histogram #(
   parameter int COLUMNS    = wih_pkg::DEF_COLUMNS,
   parameter int COUNT_BITS = wih_pkg::DEF_COUNT_BITS,
   parameter int SHIFT      = wih_pkg::DEF_SHIFT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire wih_pkg::req_type                    req_payload,
   output logic                                     rsp_valid,
   output wih_pkg::rsp_type                         rsp_payload,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [wih_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [wih_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import wih_pkg::*;

   localparam int COL_BITS  = $clog2(COLUMNS);
   localparam int ADDR_BITS = COL_BITS + LEVEL_BITS;
   localparam int DEPTH     = COLUMNS * LEVELS;
   localparam int PROD_BITS = INDEX_BITS + XSCALE_BITS;
   localparam int SPAN_BITS = LEVEL_BITS + 1 + GAIN_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_LOOKUP,
      ST_DATA
   } state_type;

   state_type              state_ff;
   req_type                req_ff;
   logic [PROD_BITS-1:0]   col_prod_ff;
   span_type               span_ff;
   logic [ADDR_BITS-1:0]   addr_ff;
   logic [ADDR_BITS-1:0]   clr_addr_ff;
   logic                   zero_ff;

   logic [XSCALE_BITS-1:0] x_scale_ff;
   logic [GAIN_BITS-1:0]   color_red_ff, color_green_ff, color_blue_ff;
   logic [GAIN_BITS-1:0]   row_scale_ff;
   logic [ROW_BITS-1:0]    display_height_ff;

   logic [COUNT_BITS-1:0]  hit_store [DEPTH];
   logic [COUNT_BITS-1:0]  rd_data_ff;

   logic                   accept;
   logic [PROD_BITS-1:0]   col_full;
   logic                   col_in_range;
   logic                   level_counted;
   logic                   read_in_range;
   logic [COL_BITS-1:0]    cell_col;
   logic [LEVEL_BITS-1:0]  cell_level;
   logic [ADDR_BITS-1:0]   lookup_addr;
   logic                   mem_re;
   logic                   mem_we;
   logic [ADDR_BITS-1:0]   mem_waddr;
   logic [COUNT_BITS-1:0]  mem_wdata;
   logic [SPAN_BITS-1:0]   span_lo_prod, span_hi_prod;
   logic                   shade_go;
   logic [COUNT_BITS-1:0]  shade_count;
   shade_cfg_type          shade_cfg;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // Register file; a write to an index past the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         x_scale_ff        <= RST_X_SCALE;
         color_red_ff      <= RST_GAIN;
         color_green_ff    <= RST_GAIN;
         color_blue_ff     <= RST_GAIN;
         row_scale_ff      <= RST_ROW_SCALE;
         display_height_ff <= RST_DISPLAY_HEIGHT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_X_SCALE:        x_scale_ff        <= csr_data;
            CSR_COLOR_RED:      color_red_ff      <= csr_data[GAIN_BITS-1:0];
            CSR_COLOR_GREEN:    color_green_ff    <= csr_data[GAIN_BITS-1:0];
            CSR_COLOR_BLUE:     color_blue_ff     <= csr_data[GAIN_BITS-1:0];
            CSR_ROW_SCALE:      row_scale_ff      <= csr_data[GAIN_BITS-1:0];
            CSR_DISPLAY_HEIGHT: display_height_ff <= csr_data[ROW_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Row span of the read level, worked out at accept.
   assign span_lo_prod = SPAN_BITS'(req_payload.read_level) * SPAN_BITS'(row_scale_ff);
   assign span_hi_prod = (SPAN_BITS'(req_payload.read_level) + SPAN_BITS'(1))
                         * SPAN_BITS'(row_scale_ff);

   // Cell selection for the lookup cycle.
   assign col_full      = col_prod_ff >> SHIFT;
   assign col_in_range  = (col_full < PROD_BITS'(COLUMNS));
   assign level_counted = (req_ff.sample_value != LEVEL_FLOOR)
                          && (req_ff.sample_value != LEVEL_CEIL);
   assign read_in_range = (32'(req_ff.read_column) < 32'(COLUMNS));

   always_comb begin
      if (req_ff.func == FUNC_READ) begin
         cell_col   = COL_BITS'(req_ff.read_column);
         cell_level = req_ff.read_level;
      end else begin
         cell_col   = col_full[COL_BITS-1:0];
         cell_level = req_ff.sample_value;
      end
   end

   assign lookup_addr = {cell_col, cell_level};

   // Sequencer: accept, look up, then write back or hand to shading, or run the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (req_payload.func)
                     FUNC_ACCUM, FUNC_READ: begin
                        state_ff <= ST_LOOKUP;
                     end
                     FUNC_CLEAR: begin
                        state_ff    <= ST_CLEAR;
                        clr_addr_ff <= '0;
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + ADDR_BITS'(1);
               if (clr_addr_ff == ADDR_BITS'(DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_LOOKUP: begin
               if (req_ff.func == FUNC_ACCUM && !(col_in_range && level_counted)) begin
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_DATA;
               end
            end
            ST_DATA: begin
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
      if (accept) begin
         req_ff          <= req_payload;
         col_prod_ff     <= PROD_BITS'(req_payload.sample_index) * PROD_BITS'(x_scale_ff);
         span_ff.span_lo <= span_lo_prod[ROW_BITS+7:8];
         span_ff.span_hi <= span_hi_prod[ROW_BITS+7:8];
      end
      if (state_ff == ST_LOOKUP) begin
         addr_ff <= lookup_addr;
         zero_ff <= !read_in_range;
      end
   end

   // Memory port control; the item in hand owns the memory until it leaves.
   assign mem_re = (state_ff == ST_LOOKUP);

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = (state_ff == ST_DATA) && (req_ff.func == FUNC_ACCUM) && !(&rd_data_ff);
         mem_waddr = addr_ff;
         mem_wdata = rd_data_ff + COUNT_BITS'(1);
      end
   end

   // Hit-count store.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hit_store[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= hit_store[lookup_addr];
      end
   end

   // Shading of a read cell.
   assign shade_go    = (state_ff == ST_DATA) && (req_ff.func == FUNC_READ);
   assign shade_count = zero_ff ? '0 : rd_data_ff;

   assign shade_cfg.color_red      = color_red_ff;
   assign shade_cfg.color_green    = color_green_ff;
   assign shade_cfg.color_blue     = color_blue_ff;
   assign shade_cfg.display_height = display_height_ff;

   wih_shade #(
      .COUNT_BITS (COUNT_BITS)
   ) u_shade (
      .clock       (clock),
      .reset       (reset),
      .go          (shade_go),
      .count       (shade_count),
      .column      (req_ff.read_column),
      .span        (span_ff),
      .cfg         (shade_cfg),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // A result beat never lasts longer than one cycle, since items are spaced.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // An accepted read yields its result beat after the lookup and data states and the shading stages.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.func == FUNC_READ) |-> ##4 rsp_valid)
      else $error("read result missing");

   // Accumulate and read keep the block busy for the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_payload.func == FUNC_ACCUM || req_payload.func == FUNC_READ))
      |=> busy)
      else $error("block idle right after taking an item");

   // The write-back only ever happens in the cycle after a lookup.
   assert property (@(posedge clock) disable iff (reset)
      (mem_we && state_ff != ST_CLEAR) |-> $past(state_ff == ST_LOOKUP))
      else $error("store written without a preceding lookup");

endmodule

`default_nettype wire
